[rtl/dqd_pkg.sv]
package dqd_pkg;

  // Default number of encoder channels held in the state memory.
  localparam int EncodersDefault = 2;

  localparam int CfgDataW = 32;
  localparam int CfgAddrW = 3;

  localparam logic [3:0] DebounceReset = 4'd2;
  localparam logic [3:0] PulsesReset   = 4'd4;

  // Stable pin sample {B, A} to quadrature phase.
  localparam logic [1:0] PhaseTable [4] = '{2'd2, 2'd3, 2'd1, 2'd0};

  // Register index, taken from paddr[2].
  typedef enum logic [0:0] {
    REG_DEBOUNCE = 1'b0,
    REG_PULSES   = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [3:0] debounce_cycles;
    logic [3:0] pulses_per_event;
  } cfg_t;

  // Per-channel state, one memory word.
  typedef struct packed {
    logic        [1:0] candidate;
    logic        [3:0] repeat_cnt;
    logic        [1:0] stable;
    logic        [1:0] last_phase;
    logic signed [5:0] pulse_cnt;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

endpackage

[rtl/dqd_ram.sv]
module dqd_ram #(
  parameter  int Width = 16,
  parameter  int Depth = 2,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Read returns the old word when read and write hit the same address.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/dqd_cfg.sv]
module dqd_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dqd_pkg::CfgAddrW-1:0]    paddr,
  input  logic [dqd_pkg::CfgDataW-1:0]    pwdata,
  output logic [dqd_pkg::CfgDataW-1:0]    prdata,
  output logic                            pready,
  output dqd_pkg::cfg_t                   cfg_o
);
  import dqd_pkg::*;

  cfg_t     cfg_q, cfg_d;
  cfg_reg_e sel;
  logic     wr_en;

  assign sel   = cfg_reg_e'(paddr[2]);
  assign wr_en = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (sel)
        REG_DEBOUNCE: cfg_d.debounce_cycles  = pwdata[3:0];
        REG_PULSES:   cfg_d.pulses_per_event = pwdata[3:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_DEBOUNCE: prdata = {{(CfgDataW-4){1'b0}}, cfg_q.debounce_cycles};
      REG_PULSES:   prdata = {{(CfgDataW-4){1'b0}}, cfg_q.pulses_per_event};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_cycles  <= DebounceReset;
      cfg_q.pulses_per_event <= PulsesReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/dqd_update.sv]
module dqd_update (
  input  dqd_pkg::entry_t cur_i,
  input  logic [1:0]      sample_i,
  input  dqd_pkg::cfg_t   cfg_i,
  output dqd_pkg::entry_t nxt_o,
  output logic            up_o,
  output logic            down_o
);
  import dqd_pkg::*;

  logic              [1:0] phase;
  logic              [1:0] ahead;
  logic              [1:0] behind;
  logic signed       [5:0] ppe;
  logic signed       [5:0] inc;
  logic signed       [5:0] dec;

  assign ppe = $signed({2'b00, cfg_i.pulses_per_event});
  assign inc = cur_i.pulse_cnt + 6'sd1;
  assign dec = cur_i.pulse_cnt - 6'sd1;

  always_comb begin
    nxt_o  = cur_i;
    up_o   = 1'b0;
    down_o = 1'b0;

    // Debounce.
    if (sample_i == cur_i.candidate) begin
      if (cur_i.repeat_cnt < cfg_i.debounce_cycles) begin
        nxt_o.repeat_cnt = cur_i.repeat_cnt + 4'd1;
      end else begin
        nxt_o.stable = sample_i;
      end
    end else begin
      nxt_o.candidate  = sample_i;
      nxt_o.repeat_cnt = 4'd0;
    end

    phase  = PhaseTable[nxt_o.stable];
    ahead  = phase + 2'd1;
    behind = phase + 2'd3;

    // Quadrature step on a change of the stable value; double jumps drop.
    if (nxt_o.stable != cur_i.stable) begin
      if (cur_i.last_phase == behind) begin
        if (inc >= ppe) begin
          up_o            = 1'b1;
          nxt_o.pulse_cnt = 6'sd0;
        end else begin
          nxt_o.pulse_cnt = inc;
        end
      end else if (cur_i.last_phase == ahead) begin
        if (dec <= 6'sd0) begin
          down_o          = 1'b1;
          nxt_o.pulse_cnt = ppe;
        end else begin
          nxt_o.pulse_cnt = dec;
        end
      end
      nxt_o.last_phase = phase;
    end
  end

endmodule

[rtl/debounced_quadrature_decoder.sv]
// Debounced quadrature decoder for up to two encoder channels.
//
// Input channel: one beat per pin sample tick (channel_i, pin_a_i, pin_b_i),
// taken at a rising edge with in_valid_i high and in_stall_o low.
// Output channel: exactly one beat per input beat, in order, carrying the
// channel and the step_up_o / step_down_o event flags for that tick.
//
// An accepted beat moves through the update stage, then the output register.
// Throughput: one beat per cycle while out_stall_i is low, for any mix of
// channels. The per-channel state sits in a small RAM with a registered
// read; the accept edge reads the entry, and the update stage updates it and
// writes it back. A write-back register forwards the newest entry when the
// same channel comes back to back, so the RAM port pair sets the one-cycle rate.
//
// Reset: configuration returns to debounce_cycles = 2 and
// pulses_per_event = 4; per-entry valid flops clear, so every channel
// reads as all-zero state until first written. No clearing pass.
// Stall: an output beat held by out_stall_i stays put; one more beat can
// sit in the update stage, after which in_stall_o rises. Configuration is an
// APB-style port; the user writes it only while the block is idle, unenforced.
module debounced_quadrature_decoder #(
  parameter int ENCODERS = dqd_pkg::EncodersDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // config port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dqd_pkg::CfgAddrW-1:0] paddr,
  input  logic [dqd_pkg::CfgDataW-1:0] pwdata,
  output logic [dqd_pkg::CfgDataW-1:0] prdata,
  output logic                         pready,
  // sample input
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         channel_i,
  input  logic                         pin_a_i,
  input  logic                         pin_b_i,
  // event output
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         out_channel_o,
  output logic                         step_up_o,
  output logic                         step_down_o
);
  import dqd_pkg::*;

  localparam int AddrW = (ENCODERS > 1) ? $clog2(ENCODERS) : 1;

  cfg_t cfg;

  dqd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Handshake.
  logic in_acc;
  logic s1_go;

  // Update stage.
  logic             s1_valid_q;
  logic             s1_chan_q;
  logic [1:0]       s1_sample_q;
  logic             rd_valid_q;
  logic [AddrW-1:0] s1_addr;
  logic             s1_present;

  // Entry valid flops, one per channel.
  logic [ENCODERS-1:0] ent_valid_q;

  // Write-back forwarding.
  logic             fwd_valid_q;
  logic [AddrW-1:0] fwd_addr_q;
  entry_t           fwd_data_q;

  // Output register.
  logic out_valid_q;
  logic out_chan_q;
  logic out_up_q;
  logic out_down_q;

  logic [EntryW-1:0] rd_data;
  entry_t            cur_ent;
  entry_t            nxt_ent;
  logic              upd_up;
  logic              upd_down;
  logic              wr_en;
  logic [AddrW-1:0]  in_addr;

  assign in_addr    = AddrW'(channel_i);
  assign s1_addr    = AddrW'(s1_chan_q);
  assign s1_present = (32'(s1_chan_q) < ENCODERS);

  // Update stage moves whenever the output register has room this edge.
  assign s1_go      = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_go;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign wr_en      = s1_valid_q && s1_go && s1_present;

  dqd_ram #(
    .Width (EntryW),
    .Depth (ENCODERS)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (s1_addr),
    .wdata_i (nxt_ent),
    .re_i    (in_acc),
    .raddr_i (in_addr),
    .rdata_o (rd_data)
  );

  // Newest copy of the entry: forwarded, from RAM, or reset value.
  always_comb begin
    if (fwd_valid_q && (fwd_addr_q == s1_addr)) begin
      cur_ent = fwd_data_q;
    end else if (rd_valid_q) begin
      cur_ent = entry_t'(rd_data);
    end else begin
      cur_ent = '0;
    end
  end

  dqd_update u_update (
    .cur_i    (cur_ent),
    .sample_i (s1_sample_q),
    .cfg_i    (cfg),
    .nxt_o    (nxt_ent),
    .up_o     (upd_up),
    .down_o   (upd_down)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      rd_valid_q  <= 1'b0;
      ent_valid_q <= '0;
      fwd_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
        rd_valid_q <= (32'(channel_i) < ENCODERS) ? ent_valid_q[in_addr] : 1'b0;
      end else if (s1_go) begin
        s1_valid_q <= 1'b0;
      end

      if (wr_en) begin
        ent_valid_q[s1_addr] <= 1'b1;
        fwd_valid_q          <= 1'b1;
      end

      if (s1_valid_q && s1_go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_chan_q   <= channel_i;
      s1_sample_q <= {pin_b_i, pin_a_i};
    end
    if (wr_en) begin
      fwd_addr_q <= s1_addr;
      fwd_data_q <= nxt_ent;
    end
    if (s1_valid_q && s1_go) begin
      out_chan_q <= s1_chan_q;
      out_up_q   <= upd_up && s1_present;
      out_down_q <= upd_down && s1_present;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_channel_o = out_chan_q;
  assign step_up_o     = out_up_q;
  assign step_down_o   = out_down_q;

  // Assertions.
  a_one_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(step_up_o && step_down_o))
    else $error("both step events in one beat");

  a_absent_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (32'(out_channel_o) >= ENCODERS)) |-> (!step_up_o && !step_down_o))
    else $error("event on a channel that is not present");

  a_pulse_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> ((nxt_ent.pulse_cnt >= 6'sd0) && (nxt_ent.pulse_cnt <= 6'sd16)))
    else $error("pulse count out of range on write-back");

  a_stage_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_go) |=> out_valid_o)
    else $error("update stage beat lost before output register");

endmodule

[tb/sv/tb_debounced_quadrature_decoder.sv]
`timescale 1ns / 100ps

typedef struct {
  bit ch;
  bit up;
  bit down;
} tick_event_t;

// Tracks the decoder per channel and holds the events each accepted beat should produce.
class quad_tick_board;
  bit [3:0] dbc;
  bit [3:0] ppe;
  bit [1:0] cand [2];
  bit [3:0] rep [2];
  bit [1:0] stable [2];
  bit [1:0] last_ph [2];
  int pulses [2];
  tick_event_t expected_ticks [$];
  int errors;
  int n_beats;
  int n_up;
  int n_down;

  function new();
    dbc = 4'd2;
    ppe = 4'd4;
    for (int i = 0; i < 2; i++) begin
      cand[i] = '0;
      rep[i] = '0;
      stable[i] = '0;
      last_ph[i] = '0;
      pulses[i] = 0;
    end
    errors = 0;
    n_beats = 0;
    n_up = 0;
    n_down = 0;
  endfunction

  // Pin sample {B, A} to phase; walking phases upward is the forward direction.
  function bit [1:0] phase_for(bit [1:0] smp);
    case (smp)
      2'b00: return 2'd2;
      2'b01: return 2'd3;
      2'b10: return 2'd1;
      default: return 2'd0;
    endcase
  endfunction

  function void predict_tick(bit ch, bit a, bit b);
    bit [1:0] smp;
    bit [1:0] was;
    bit [1:0] ph;
    bit [1:0] ahead;
    bit [1:0] behind;
    tick_event_t ev;
    smp = {b, a};
    was = stable[ch];
    ev.ch = ch;
    ev.up = 1'b0;
    ev.down = 1'b0;
    if (smp == cand[ch]) begin
      if (rep[ch] < dbc) rep[ch] = rep[ch] + 4'd1;
      else stable[ch] = smp;
    end else begin
      cand[ch] = smp;
      rep[ch] = '0;
    end
    if (stable[ch] != was) begin
      ph = phase_for(stable[ch]);
      ahead = ph + 2'd1;
      behind = ph + 2'd3;
      if (last_ph[ch] == behind) begin
        pulses[ch]++;
        if (pulses[ch] >= int'(ppe)) begin
          ev.up = 1'b1;
          pulses[ch] = 0;
        end
      end else if (last_ph[ch] == ahead) begin
        pulses[ch]--;
        if (pulses[ch] <= 0) begin
          ev.down = 1'b1;
          pulses[ch] = int'(ppe);
        end
      end
      // a two-phase jump only moves the phase
      last_ph[ch] = ph;
    end
    expected_ticks.push_back(ev);
    n_beats++;
  endfunction

  function void check_tick(bit ch, bit up, bit down);
    tick_event_t ev;
    if (expected_ticks.size() == 0) begin
      $display("%0t: output beat with nothing expected: ch=%0d up=%0d down=%0d",
               $time, ch, up, down);
      errors++;
      return;
    end
    ev = expected_ticks.pop_front();
    if (up) n_up++;
    if (down) n_down++;
    if (ch != ev.ch) begin
      $display("%0t: out_channel expected %0d, got %0d", $time, ev.ch, ch);
      errors++;
    end
    if (up != ev.up) begin
      $display("%0t: step_up (ch %0d) expected %0d, got %0d", $time, ev.ch, ev.up, up);
      errors++;
    end
    if (down != ev.down) begin
      $display("%0t: step_down (ch %0d) expected %0d, got %0d", $time, ev.ch, ev.down, down);
      errors++;
    end
  endfunction
endclass

module tb_debounced_quadrature_decoder;
  import dqd_pkg::*;

  localparam int CycleLimit = 200000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // config port
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CfgAddrW-1:0] paddr = '0;
  logic [CfgDataW-1:0] pwdata = '0;
  logic [CfgDataW-1:0] prdata;
  logic pready;

  // sample beats in, event beats out
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic channel_i = 1'b0;
  logic pin_a_i = 1'b0;
  logic pin_b_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic out_channel_o;
  logic step_up_o;
  logic step_down_o;

  quad_tick_board sb;

  // steady: no idling on either side while it is set
  bit steady = 1'b0;
  int cycles = 0;
  int n_settings = 0;

  // per-channel walk state for the random part
  bit [1:0] aim [2] = '{2'b00, 2'b00};
  int hold [2] = '{0, 0};
  bit fwd [2] = '{1'b1, 1'b0};

  debounced_quadrature_decoder dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .channel_i    (channel_i),
    .pin_a_i      (pin_a_i),
    .pin_b_i      (pin_b_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_channel_o(out_channel_o),
    .step_up_o    (step_up_o),
    .step_down_o  (step_down_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 0;
  end

  // Receiver backpressure: about 23% of cycles stalled, none in the steady window.
  always @(posedge clk_i) begin
    out_stall_i <= !steady && ($urandom_range(0, 99) < 23);
  end

  // Monitor both channels on the same edge. Output is checked first; an
  // output beat can never belong to an input accepted at that very edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_tick(out_channel_o, step_up_o, step_down_o);
      if (in_valid_i && !in_stall_o) sb.predict_tick(channel_i, pin_a_i, pin_b_i);
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d beats still expected",
               cycles, sb.expected_ticks.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Forward walk in sample space is 3 -> 2 -> 0 -> 1 -> 3 (phases 0,1,2,3).
  function automatic bit [1:0] next_sample(bit [1:0] smp, bit go_fwd);
    case (smp)
      2'b11: return go_fwd ? 2'b10 : 2'b01;
      2'b10: return go_fwd ? 2'b00 : 2'b11;
      2'b00: return go_fwd ? 2'b01 : 2'b10;
      default: return go_fwd ? 2'b11 : 2'b00;
    endcase
  endfunction

  // One input beat; random idle cycles ahead of it, then hold until accepted.
  // Valid stays high when the next call has no gap, so it is never toggled in one step.
  task automatic send_beat(input bit ch, input bit a, input bit b);
    while (!steady && $urandom_range(0, 99) < 23) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    channel_i <= ch;
    pin_a_i <= a;
    pin_b_i <= b;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Hold a sample long enough for a debounce setting of zero to take it.
  task automatic step_to(input bit ch, input bit [1:0] smp);
    send_beat(ch, smp[0], smp[1]);
    send_beat(ch, smp[0], smp[1]);
  endtask

  // Block idle: every event beat back, then the pipeline depth plus margin.
  // First wait on the clock so the monitor has logged the last accepted beat.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_ticks.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Setup then access phase; follow with a read of the same register.
  task automatic write_reg(input cfg_reg_e idx, input logic [3:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {{(CfgDataW-4){1'b0}}, val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == REG_DEBOUNCE) sb.dbc = val;
    else sb.ppe = val;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[3:0] !== val) begin
      $display("%0t: read of %s expected %0d, got %0d", $time, idx.name(), val, prdata[3:0]);
      sb.errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_setting(input logic [3:0] dbc, input logic [3:0] ppe);
    drain();
    write_reg(REG_DEBOUNCE, dbc);
    write_reg(REG_PULSES, ppe);
    n_settings++;
  endtask

  // Mostly well-formed quadrature walks per channel, each new sample held long
  // enough to pass debounce, with direction flips, two-phase jumps and glitches.
  task automatic random_walk(input int beats);
    bit ch;
    bit [1:0] smp;
    repeat (beats) begin
      ch = $urandom_range(0, 1);
      if ($urandom_range(0, 99) < 12) begin
        smp = $urandom_range(0, 3);
      end else begin
        if (hold[ch] == 0) begin
          if ($urandom_range(0, 99) < 15) fwd[ch] = !fwd[ch];
          if ($urandom_range(0, 99) < 6) aim[ch] = ~aim[ch];
          else aim[ch] = next_sample(aim[ch], fwd[ch]);
          hold[ch] = int'(sb.dbc) + 2 + $urandom_range(0, 1);
        end
        smp = aim[ch];
        hold[ch]--;
      end
      send_beat(ch, smp[0], smp[1]);
    end
  endtask

  initial begin
    logic [3:0] db_set [7];
    logic [3:0] pp_set [7];
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, debounce 0 / one pulse per event.
    apply_setting(4'd0, 4'd1);
    // First change after reset: last phase is 0, sample 1 is phase 3 -> backward.
    step_to(1'b0, 2'b01);
    step_to(1'b0, 2'b11);
    step_to(1'b0, 2'b10);
    step_to(1'b0, 2'b00);
    // two-phase jump, ignored
    step_to(1'b0, 2'b11);
    step_to(1'b1, 2'b10);
    step_to(1'b1, 2'b11);

    // Zero pulses per event: every step fires.
    apply_setting(4'd0, 4'd0);
    step_to(1'b0, 2'b10);
    step_to(1'b0, 2'b11);

    // Count to 4 at 15 per event, then lower the limit below the count.
    apply_setting(4'd0, 4'd15);
    step_to(1'b1, 2'b10);
    step_to(1'b1, 2'b00);
    step_to(1'b1, 2'b01);
    apply_setting(4'd0, 4'd1);
    step_to(1'b1, 2'b11);

    // Random part over several settings, extremes included.
    aim[0] = 2'b11;
    aim[1] = 2'b11;
    db_set = '{4'd2, 4'd0, 4'd15, 4'd1, 4'd0, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15))};
    pp_set = '{4'd4, 4'd15, 4'd1, 4'd2, 4'd0, 4'($urandom_range(1, 15)), 4'($urandom_range(1, 15))};
    for (int i = 0; i < 7; i++) begin
      apply_setting(db_set[i], pp_set[i]);
      hold[0] = 0;
      hold[1] = 0;
      steady = (i == 3);
      random_walk(56);
      steady = 1'b0;
    end

    drain();
    repeat (8) @(posedge clk_i);

    $display("Ran %0d sample beats on both channels over %0d register settings,",
             sb.n_beats, n_settings);
    $display("debounce 0..15 and pulses per event 0..15; %0d increment and %0d decrement events.",
             sb.n_up, sb.n_down);
    if (sb.errors == 0 && sb.expected_ticks.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
